// File: hdl/ptat_pkg.sv
`default_nettype none

package ptat_pkg;

    // Memory geometry
    localparam int PAGE_BYTES   = 256;
    localparam int NUM_PAGES    = 64;
    localparam int POINTER_BASE = 64;
    localparam int OFF_W        = $clog2(PAGE_BYTES);
    localparam int PAGE_W       = $clog2(NUM_PAGES);
    localparam int ADDR_W       = OFF_W + PAGE_W;
    localparam int MEM_BYTES    = NUM_PAGES * PAGE_BYTES;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;
    localparam int PID_W  = 8;
    localparam int WANT_W = 7;
    localparam int VA_W   = 14;
    localparam int PA_W   = 14;
    localparam int ST_W   = 2;
    localparam int VPG_W  = VA_W - OFF_W;
    localparam int CNT_W  = PAGE_W + 1;
    // wide enough for every range compare in the sequencer
    localparam int SUM_W  = 12;

    typedef enum logic [MODE_W-1:0] {
        MODE_NEW,
        MODE_KILL,
        MODE_STORE,
        MODE_LOAD
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_NO_MEM,
        ST_UNMAPPED,
        ST_NO_PROC
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [PID_W-1:0]   proc_id;
        logic [WANT_W-1:0]  pages_wanted;
        logic [VA_W-1:0]    virt_addr;
        logic [BYTE_W-1:0]  write_byte;
    } t_cmd;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  wdata;
    } t_mem_req;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_byte;
        logic [PA_W-1:0]    xlat_addr;
        t_status            status;
    } t_result;

    // A page number byte that points at a real, nonzero page
    function automatic logic page_valid(input logic [BYTE_W-1:0] b);
        return (b != '0) && (SUM_W'(b) < SUM_W'(NUM_PAGES));
    endfunction

endpackage

`default_nettype wire

// File: hdl/ptat_ram.sv
`default_nettype none

module ptat_ram (
    input  logic                            i_clk,
    input  ptat_pkg::t_mem_req              i_req,
    output logic [ptat_pkg::BYTE_W-1:0]     o_rdata
);
    import ptat_pkg::*;

    logic [BYTE_W-1:0] r_mem [MEM_BYTES];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/ptat_seq.sv
`default_nettype none

module ptat_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  ptat_pkg::t_cmd                  i_cmd,
    output ptat_pkg::t_mem_req              o_req,
    input  logic [ptat_pkg::BYTE_W-1:0]     i_rdata,
    input  logic                            i_out_free,
    output logic                            o_res_valid,
    output ptat_pkg::t_result               o_res
);
    import ptat_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PTR_RD,
        S_PTR_EV,
        S_CNT_RD,
        S_CNT_EV,
        S_CNT_CHK,
        S_FIND_RD,
        S_FIND_EV,
        S_MARK,
        S_LINK,
        S_TCLR,
        S_KILL_RD,
        S_KILL_EV,
        S_KILL_CLR,
        S_KILL_MAP,
        S_KILL_PTR,
        S_XL_RD,
        S_XL_EV,
        S_LOAD_WAIT,
        S_DONE
    } t_state;

    t_state              r_state,     n_state;
    logic [ADDR_W-1:0]   r_clr,       n_clr;
    t_cmd                r_cmd,       n_cmd;
    logic [OFF_W-1:0]    r_ptr,       n_ptr;
    logic [PAGE_W-1:0]   r_idx,       n_idx;
    logic [CNT_W-1:0]    r_cnt,       n_cnt;
    logic [PAGE_W-1:0]   r_pg,        n_pg;
    logic [PAGE_W-1:0]   r_tpg,       n_tpg;
    logic                r_have_tbl,  n_have_tbl;
    logic [WANT_W-1:0]   r_n,         n_n;
    logic [OFF_W-1:0]    r_i,         n_i;
    t_result             r_res,       n_res;
    logic                r_res_valid, n_res_valid;

    logic [SUM_W-1:0]    w_ptr_sum;
    logic [ADDR_W-1:0]   w_ptr_addr;
    logic [ADDR_W-1:0]   w_entry_addr;
    logic [VPG_W-1:0]    w_vpage;
    logic [OFF_W-1:0]    w_off;
    logic [ADDR_W-1:0]   w_xl_addr;
    logic                w_accept;

    assign w_accept     = i_valid && (r_state == S_IDLE);
    assign w_ptr_sum    = SUM_W'(i_cmd.proc_id) + SUM_W'(POINTER_BASE);
    assign w_ptr_addr   = ADDR_W'(r_ptr);
    assign w_entry_addr = {r_tpg, r_i};
    assign w_vpage      = r_cmd.virt_addr[VA_W-1:OFF_W];
    assign w_off        = r_cmd.virt_addr[OFF_W-1:0];
    assign w_xl_addr    = {i_rdata[PAGE_W-1:0], w_off};

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_pg        = r_pg;
        n_tpg       = r_tpg;
        n_have_tbl  = r_have_tbl;
        n_n         = r_n;
        n_i         = r_i;
        n_res       = r_res;
        n_res_valid = 1'b0;
        o_req       = '{we: 1'b0, addr: w_ptr_addr, wdata: '0};

        unique case (r_state)
            S_CLEAR: begin
                // page 0 starts marked in use
                o_req.we    = 1'b1;
                o_req.addr  = r_clr;
                o_req.wdata = (r_clr == '0) ? BYTE_W'(1) : '0;
                n_clr       = r_clr + ADDR_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = i_cmd;
                    n_res = '{read_byte: '0, xlat_addr: '0, status: ST_OK};
                    n_ptr = w_ptr_sum[OFF_W-1:0];
                    if (w_ptr_sum >= SUM_W'(PAGE_BYTES)) begin
                        n_res.status = ST_NO_PROC;
                        n_state      = S_DONE;
                    end else if (i_cmd.mode == MODE_NEW) begin
                        n_idx   = '0;
                        n_cnt   = '0;
                        n_state = S_CNT_RD;
                    end else begin
                        n_state = S_PTR_RD;
                    end
                end
            end
            // free-page count
            S_CNT_RD: begin
                o_req.addr = ADDR_W'(r_idx);
                n_state    = S_CNT_EV;
            end
            S_CNT_EV: begin
                if (i_rdata == '0) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (r_idx == PAGE_W'(NUM_PAGES - 1)) begin
                    n_state = S_CNT_CHK;
                end else begin
                    n_idx   = r_idx + PAGE_W'(1);
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_CHK: begin
                if ((SUM_W'(r_cmd.pages_wanted) > SUM_W'(PAGE_BYTES)) ||
                    (SUM_W'(r_cnt) < SUM_W'(r_cmd.pages_wanted) + SUM_W'(1))) begin
                    n_res.status = ST_NO_MEM;
                    n_state      = S_DONE;
                end else begin
                    n_idx      = '0;
                    n_have_tbl = 1'b0;
                    n_n        = '0;
                    n_state    = S_FIND_RD;
                end
            end
            // lowest free page; later pages only lie above the last one taken
            S_FIND_RD: begin
                o_req.addr = ADDR_W'(r_idx);
                n_state    = S_FIND_EV;
            end
            S_FIND_EV: begin
                if (i_rdata == '0) begin
                    n_pg    = r_idx;
                    n_state = S_MARK;
                end else begin
                    n_idx   = r_idx + PAGE_W'(1);
                    n_state = S_FIND_RD;
                end
            end
            S_MARK: begin
                o_req.we    = 1'b1;
                o_req.addr  = ADDR_W'(r_pg);
                o_req.wdata = BYTE_W'(1);
                n_idx       = r_idx + PAGE_W'(1);
                n_state     = S_LINK;
            end
            S_LINK: begin
                o_req.we    = 1'b1;
                o_req.wdata = BYTE_W'(r_pg);
                if (!r_have_tbl) begin
                    o_req.addr = w_ptr_addr;
                    n_tpg      = r_pg;
                    n_have_tbl = 1'b1;
                    n_i        = '0;
                    n_state    = S_TCLR;
                end else begin
                    o_req.addr = {r_tpg, OFF_W'(r_n)};
                    n_n        = r_n + WANT_W'(1);
                    if (n_n == r_cmd.pages_wanted) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FIND_RD;
                    end
                end
            end
            S_TCLR: begin
                o_req.we   = 1'b1;
                o_req.addr = w_entry_addr;
                n_i        = r_i + OFF_W'(1);
                if (r_i == '1) begin
                    if (r_cmd.pages_wanted == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FIND_RD;
                    end
                end
            end
            S_PTR_RD: begin
                n_state = S_PTR_EV;
            end
            S_PTR_EV: begin
                if (!page_valid(i_rdata)) begin
                    n_res.status = ST_NO_PROC;
                    n_state      = S_DONE;
                end else begin
                    n_tpg = i_rdata[PAGE_W-1:0];
                    n_i   = '0;
                    if (r_cmd.mode == MODE_KILL) begin
                        n_state = S_KILL_RD;
                    end else begin
                        n_state = S_XL_RD;
                    end
                end
            end
            // kill: free each mapped page, zero each entry, then free the table page and clear the pointer
            S_KILL_RD: begin
                o_req.addr = w_entry_addr;
                n_state    = S_KILL_EV;
            end
            S_KILL_EV: begin
                if (page_valid(i_rdata)) begin
                    o_req.we   = 1'b1;
                    o_req.addr = ADDR_W'(i_rdata);
                end
                n_state = S_KILL_CLR;
            end
            S_KILL_CLR: begin
                o_req.we   = 1'b1;
                o_req.addr = w_entry_addr;
                n_i        = r_i + OFF_W'(1);
                if (r_i == '1) begin
                    n_state = S_KILL_MAP;
                end else begin
                    n_state = S_KILL_RD;
                end
            end
            S_KILL_MAP: begin
                o_req.we   = 1'b1;
                o_req.addr = ADDR_W'(r_tpg);
                n_state    = S_KILL_PTR;
            end
            S_KILL_PTR: begin
                o_req.we = 1'b1;
                n_state  = S_DONE;
            end
            // store / load translation
            S_XL_RD: begin
                o_req.addr = {r_tpg, OFF_W'(w_vpage)};
                if (SUM_W'(w_vpage) >= SUM_W'(PAGE_BYTES)) begin
                    n_res.status = ST_UNMAPPED;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_XL_EV;
                end
            end
            S_XL_EV: begin
                if (!page_valid(i_rdata)) begin
                    n_res.status = ST_UNMAPPED;
                    n_state      = S_DONE;
                end else begin
                    o_req.addr      = w_xl_addr;
                    n_res.xlat_addr = PA_W'(w_xl_addr);
                    if (r_cmd.mode == MODE_STORE) begin
                        o_req.we    = 1'b1;
                        o_req.wdata = r_cmd.write_byte;
                        n_state     = S_DONE;
                    end else begin
                        n_state = S_LOAD_WAIT;
                    end
                end
            end
            S_LOAD_WAIT: begin
                n_res.read_byte = i_rdata;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_res_valid <= n_res_valid;
        end
        r_cmd      <= n_cmd;
        r_ptr      <= n_ptr;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_pg       <= n_pg;
        r_tpg      <= n_tpg;
        r_have_tbl <= n_have_tbl;
        r_n        <= n_n;
        r_i        <= n_i;
        r_res      <= n_res;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// File: hdl/page_table_allocator_and_translator_core.sv
// Page-table allocator and translator over a 16 KiB byte memory (64 pages x 256 B).
// Input channel: i_valid / o_stall, one command per beat (mode, proc_id,
// pages_wanted, virt_addr, write_byte). Output channel: o_valid / i_stall, one
// result beat per command (read_byte, xlat_addr, status).
// Commands run one at a time through a sequencer around a single-port byte RAM
// with a registered read.
// Kill reads, frees and clears each of the 256 table entries, then frees the
// table page and clears the pointer. A new process scans the 64-byte free map,
// takes the lowest free page as its table and points the process at it, clears
// the table's 256 bytes, then finds, marks and links each data page.
// o_stall is high from accept until the result moves into the output register.
// Results land in that register, so the next command is taken while a result
// beat waits; a finished result that cannot move keeps o_stall high.
// Reset (i_rst_n, synchronous): a clearing pass writes all 16384 bytes, one
// per cycle, setting byte 0 to 1; o_stall stays high until the pass ends.
// A stalled result holds steady until taken.
`default_nettype none

module page_table_allocator_and_translator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ptat_pkg::MODE_W-1:0]     i_mode,
    input  logic [ptat_pkg::PID_W-1:0]      i_proc_id,
    input  logic [ptat_pkg::WANT_W-1:0]     i_pages_wanted,
    input  logic [ptat_pkg::VA_W-1:0]       i_virt_addr,
    input  logic [ptat_pkg::BYTE_W-1:0]     i_write_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ptat_pkg::BYTE_W-1:0]     o_read_byte,
    output logic [ptat_pkg::PA_W-1:0]       o_xlat_addr,
    output logic [ptat_pkg::ST_W-1:0]       o_status
);
    import ptat_pkg::*;

    t_cmd               w_cmd;
    t_mem_req           w_req;
    logic [BYTE_W-1:0]  w_rdata;
    t_result            w_res;
    logic               w_res_valid;
    logic               w_out_free;

    logic               r_out_valid;
    t_result            r_out;

    assign w_cmd = '{mode:         t_mode'(i_mode),
                     proc_id:      i_proc_id,
                     pages_wanted: i_pages_wanted,
                     virt_addr:    i_virt_addr,
                     write_byte:   i_write_byte};

    // State memory: free map and pointers in page 0, tables and data elsewhere
    ptat_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // Command sequencer: read-modify-write walks over the RAM
    ptat_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (w_cmd),
        .o_req       (w_req),
        .i_rdata     (w_rdata),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Output register: empty, or emptied at this edge
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_byte = r_out.read_byte;
    assign o_xlat_addr = r_out.xlat_addr;
    assign o_status    = r_out.status;

`ifndef SYNTH
    // A new result never overwrites one still held in the output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !r_out_valid)
        else $error("result overwrote pending output beat");

    // Failed commands report no address and no data
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_xlat_addr == '0 && o_read_byte == '0))
        else $error("error beat carries address or data");

    // Right after reset the clearing pass holds off input and no result shows
    a_reset_quiet: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> (o_stall && !o_valid))
        else $error("block not quiet after reset");
`endif

endmodule

`default_nettype wire
